### design/ipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// shared types and constants for the integer printf formatter
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_UDEC = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_HEXL = 3'd3;
    localparam logic [2:0] CONV_HEXU = 3'd4;

    localparam logic [1:0] LEN_INT   = 2'd0;
    localparam logic [1:0] LEN_SHORT = 2'd1;

    localparam int DIG_BUF = 24;
    localparam int DIG_CW  = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  conversion;
        logic [1:0]  length;
        logic        left_justify;
        logic        force_sign;
        logic        space_sign;
        logic        alternate_form;
        logic        zero_pad;
        logic [6:0]  field_width;
        logic [5:0]  digit_precision;
        logic        precision_given;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIGITS, ST_LEAD, ST_SIGN, ST_PFX0, ST_PFXX, ST_ZEROS, ST_BODY
    } t_state;

    // one step of the shared divider: quotient and remainder by the base
    typedef struct packed {
        logic [63:0] quo;
        logic [3:0]  rem;
    } t_div_res;

    function automatic logic [7:0] f_digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) c = CH_ZERO + {4'd0, d};
        else c = (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

### design/ipf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_divider
// quotient and remainder of a 64-bit value by 8, 10 or 16
// ----------------------------------------------------------------------------
// base 8 and 16 are a shift and a mask, ready in the cycle after i_go.
// base 10 runs four steps over 16-bit chunks, most significant first: each
// step divides {remainder, chunk} by 10 with a reciprocal multiply, and
// o_done rises once the last step is registered
module ipf_divider
    import ipf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [4:0]  i_base,
    output logic        o_done,
    output t_div_res    o_res
);

    logic [63:0] r_num, n_num;
    logic [63:0] r_quo, n_quo;
    logic [3:0]  r_rem, n_rem;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [19:0] w_x;
    logic [39:0] w_prod;
    logic [15:0] w_q;
    logic [3:0]  w_rem;

    always_comb begin
        // x / 10 = (x * ceil(2^23 / 10)) >> 23, exact for x below 2^22
        w_x    = {r_rem, r_num[63:48]};
        w_prod = {20'd0, w_x} * 40'd838861;
        w_q    = w_prod[38:23];
        // remainder below 10, so the low four bits of x - 10q are enough
        w_rem  = w_x[3:0] - ({w_q[0], 3'd0} + {w_q[2:0], 1'b0});
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_go) begin
            if (i_base == 5'd8) begin
                n_quo  = {3'd0, i_num[63:3]};
                n_rem  = {1'b0, i_num[2:0]};
                n_done = 1'b1;
            end else if (i_base == 5'd16) begin
                n_quo  = {4'd0, i_num[63:4]};
                n_rem  = i_num[3:0];
                n_done = 1'b1;
            end else begin
                n_num  = i_num;
                n_rem  = 4'd0;
                n_cnt  = 2'd0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_quo = {r_quo[47:0], w_q};
            n_rem = w_rem;
            n_num = {r_num[47:0], 16'd0};
            n_cnt = r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done    = r_done;
    assign o_res.quo = r_quo;
    assign o_res.rem = r_rem;

endmodule

### design/integer_printf_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_printf_formatter
// formats one integer as printf %d %i %u %o %x %X, one character per beat
// ----------------------------------------------------------------------------
// a conversion is taken when start is high and busy is low. digits are
// pulled out by one shared divider, for decimal (up to 20 digits) and for
// octal and hex (up to 22 and 16), each nonzero quotient launching the
// next digit. the setup state ST_LEAD then fixes the layout, and the
// characters follow at one beat per cycle, o_valid marking each, except
// that a state passes with no beat for each of the sign, the hex prefix
// and the zero run that is absent. the receiver cannot stall: every beat
// is valid for exactly one cycle, and o_out.last flags the final
// character. busy stays high from acceptance until the cycle that shows
// the last beat, in which a new conversion may already be taken.
module integer_printf_formatter
    import ipf_pkg::*;
#(
    parameter int MAX_FIELD = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_in,
    output logic      o_valid,
    output t_out_beat o_out
);

    localparam int CW = $clog2(MAX_FIELD + 1) + 1;

    t_state      r_st, n_st;
    t_in_beat    r_in, n_in;
    logic [63:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [7:0]  r_dig [DIG_BUF];
    logic [DIG_CW-1:0] r_nd, n_nd;
    logic [CW-1:0] r_cnt, n_cnt;    // counter for pad, zero and digit runs
    logic [CW-1:0] r_rest, n_rest;  // characters left, current one included
    logic          r_ov, n_ov;
    t_out_beat     r_ob, n_ob;
    logic          w_go;
    logic          w_ddone;
    t_div_res      w_dres;
    logic [4:0]    w_base;
    logic          w_upper;

    // derived layout values
    logic [2:0]  w_conv;
    logic [CW-1:0] w_prec, w_nout, w_width, w_body, w_pad, w_zeros, w_total, w_ndx;
    logic [7:0]  w_sgn;
    logic        w_hassgn, w_pfx, w_zp;

    assign w_conv  = (r_in.conversion > CONV_HEXU) ? CONV_UDEC : r_in.conversion;
    assign w_upper = (w_conv == CONV_HEXU);
    assign w_base  = (w_conv == CONV_OCT) ? 5'd8 :
                     ((w_conv == CONV_HEXL || w_conv == CONV_HEXU) ? 5'd16 : 5'd10);

    // the next quotient is handed straight back in when the divider restarts
    ipf_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_go),
        .i_num  (n_mag),
        .i_base (w_base),
        .o_done (w_ddone),
        .o_res  (w_dres)
    );

    always_comb begin
        logic [CW-1:0] mn;
        w_ndx  = CW'(r_nd);
        w_prec = CW'(1);
        if (r_in.precision_given)
            w_prec = (CW'(r_in.digit_precision) > CW'(MAX_FIELD - 2)) ?
                     CW'(MAX_FIELD - 2) : CW'(r_in.digit_precision);
        mn = (w_ndx > w_prec) ? w_ndx : w_prec;
        if (w_conv == CONV_OCT && r_in.alternate_form && mn == w_ndx && r_mag != 64'd0)
            mn = w_ndx + CW'(1);
        w_sgn = 8'd0;
        if (w_conv == CONV_SDEC) begin
            if (r_neg) w_sgn = CH_MINUS;
            else if (r_in.force_sign) w_sgn = CH_PLUS;
            else if (r_in.space_sign) w_sgn = CH_SPACE;
        end
        w_hassgn = (w_sgn != 8'd0);
        w_pfx = (w_conv == CONV_HEXL || w_conv == CONV_HEXU) && r_in.alternate_form
                && r_mag != 64'd0;
        w_width = (CW'(r_in.field_width) > CW'(MAX_FIELD)) ?
                  CW'(MAX_FIELD) : CW'(r_in.field_width);
        w_body = CW'(w_hassgn) + (w_pfx ? CW'(2) : CW'(0)) + mn;
        w_pad  = (w_width > w_body) ? w_width - w_body : CW'(0);
        w_zp   = r_in.zero_pad && !r_in.left_justify && !r_in.precision_given;
        w_nout = w_zp ? mn + w_pad : mn;
        if (w_zp) w_pad = CW'(0);
        w_zeros = w_nout - w_ndx;
        // zero padding sits in nout, so count it from there
        w_total = CW'(w_hassgn) + (w_pfx ? CW'(2) : CW'(0)) + w_nout + w_pad;
    end

    // accept, find digits, emit characters; rest counts down to last beat
    always_comb begin
        logic [63:0] m;
        n_st   = r_st;
        n_in   = r_in;
        n_mag  = r_mag;
        n_neg  = r_neg;
        n_nd   = r_nd;
        n_cnt  = r_cnt;
        n_rest = r_rest;
        n_ov   = 1'b0;
        n_ob   = r_ob;
        w_go   = 1'b0;
        m      = 64'd0;
        case (r_st)
            ST_IDLE: begin
                if (start) begin
                    n_in  = i_in;
                    n_nd  = '0;
                    n_cnt = '0;
                    case (i_in.length)
                        LEN_SHORT: m = {48'd0, i_in.value[15:0]};
                        LEN_INT:   m = {32'd0, i_in.value[31:0]};
                        default:   m = i_in.value;
                    endcase
                    n_neg = 1'b0;
                    if (i_in.conversion == CONV_SDEC) begin
                        if (i_in.length == LEN_SHORT && m[15]) begin
                            n_neg = 1'b1; m = {48'd0, 16'(~m[15:0] + 16'd1)};
                        end else if (i_in.length == LEN_INT && m[31]) begin
                            n_neg = 1'b1; m = {32'd0, 32'(~m[31:0] + 32'd1)};
                        end else if (i_in.length != LEN_SHORT && i_in.length != LEN_INT
                                     && m[63]) begin
                            n_neg = 1'b1; m = ~m + 64'd1;
                        end
                    end
                    n_mag = m;
                    n_st  = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                // kick the divider first, then on each nonzero quotient
                if (r_nd == '0 && !w_ddone && r_cnt == '0) begin
                    w_go  = 1'b1;
                    n_cnt = CW'(1);
                end
                if (w_ddone) begin
                    n_nd = r_nd + DIG_CW'(1);
                    // magnitude keeps its last nonzero value for the zero tests
                    if (w_dres.quo != 64'd0) n_mag = w_dres.quo;
                    if (w_dres.quo != 64'd0 && r_nd != DIG_CW'(DIG_BUF - 1)) begin
                        w_go = 1'b1;
                    end else begin
                        n_cnt = '0;
                        n_st  = ST_LEAD;
                    end
                end
            end
            ST_LEAD: begin
                // layout is now settled; start emitting
                n_rest = w_total;
                if (!r_in.left_justify && w_pad != '0) begin
                    n_cnt = w_pad; n_st = ST_SIGN; n_ob.character = CH_SPACE;
                    n_cnt = w_pad;
                end else n_cnt = '0;
                n_st = ST_SIGN;
            end
            default: ;
        endcase
        // emission sequencer
        if (r_st == ST_SIGN || r_st == ST_PFX0 || r_st == ST_PFXX || r_st == ST_ZEROS
            || r_st == ST_BODY) begin
            n_ov   = 1'b1;
            n_rest = r_rest - CW'(1);
            n_ob.last = (r_rest == CW'(1));
            if (r_rest == CW'(1)) n_st = ST_IDLE;
            case (r_st)
                ST_SIGN: begin
                    if (r_cnt != '0 && !r_in.left_justify) begin
                        n_ob.character = CH_SPACE; n_cnt = r_cnt - CW'(1);
                    end else if (w_hassgn) begin
                        n_ob.character = w_sgn; n_st = ST_PFX0;
                        n_cnt = CW'(0);
                    end else begin
                        n_ov = 1'b0; n_rest = r_rest; n_st = ST_PFX0;
                    end
                end
                ST_PFX0: begin
                    if (w_pfx) begin
                        n_ob.character = CH_ZERO; n_st = ST_PFXX;
                    end else begin
                        n_ov = 1'b0; n_rest = r_rest; n_st = ST_ZEROS;
                        n_cnt = w_zeros;
                    end
                end
                ST_PFXX: begin
                    n_ob.character = w_upper ? 8'h58 : 8'h78;
                    n_st = ST_ZEROS; n_cnt = w_zeros;
                end
                ST_ZEROS: begin
                    if (r_cnt != '0) begin
                        n_ob.character = CH_ZERO; n_cnt = r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) n_st = ST_BODY;
                    end else begin
                        n_ov = 1'b0; n_rest = r_rest; n_st = ST_BODY;
                    end
                    if (r_cnt == CW'(1) || r_cnt == '0) n_cnt = CW'(r_nd);
                    if (r_rest == CW'(1) && n_ov) n_st = ST_IDLE;
                end
                default: begin
                    // digits out most significant first, then right pad
                    if (r_cnt != '0) begin
                        n_ob.character = r_dig[DIG_CW'(r_cnt - CW'(1))];
                        n_cnt = r_cnt - CW'(1);
                    end else begin
                        n_ob.character = CH_SPACE;
                    end
                end
            endcase
            if (n_ov && r_rest == CW'(1)) n_st = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_ob   <= n_ob;
        r_rest <= n_rest;
        if (r_st == ST_DIGITS && w_ddone)
            r_dig[r_nd] <= f_digit_char(w_dres.rem, w_upper);
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_ov  <= 1'b0;
            r_nd  <= '0;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_ov  <= n_ov;
            r_nd  <= n_nd;
            r_cnt <= n_cnt;
        end
    end

    assign busy    = (r_st != ST_IDLE);
    assign o_valid = r_ov;
    assign o_out   = r_ob;

endmodule
